// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when pre holds, post holds in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)

`endif

`endif

// ===== rtl/gbt_pkg.sv =====
package gbt_pkg;

  // tap geometry
  localparam int HALF_TAPS = 8;
  localparam int TAP_CNT   = 2 * HALF_TAPS - 1;
  localparam int TAP_W     = $clog2(HALF_TAPS);
  localparam int IDX_W     = ($clog2(TAP_CNT) > 4) ? $clog2(TAP_CNT) : 4;
  localparam int N_W       = $clog2(2 * HALF_TAPS);

  // field widths
  localparam int DIM_W = 13;
  localparam int DEV_W = 16;
  localparam int OFS_W = 21;
  localparam int MAG_W = 20;
  localparam int WT_W  = 17;
  localparam int RAW_W = 24;
  localparam int TOT_W = 28;

  // shared divider
  localparam int NUM_W = 40;
  localparam int DEN_W = 32;
  localparam int QUO_W = 22;
  localparam int CNT_W = 5;
  localparam int Q_OFS = 21;
  localparam int Q_EXP = 22;
  localparam int Q_WT  = 17;

  // shared multiplier
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int M_W     = 25;
  localparam int K_W     = 7;

  localparam logic [RAW_W-1:0]   CENTRE_RAW  = 24'h800000;
  localparam logic [WT_W-1:0]    WEIGHT_ONE  = 17'h10000;
  localparam logic [MAG_W-1:0]   OFS_MAX     = 20'hFFFFF;
  localparam logic [QUO_W-1:0]   X_LIMIT     = 22'h200000;
  localparam logic [MUL_B_W-1:0] LOG2E_Q16   = 24'd94548;
  localparam logic [M_W-1:0]     M_ONE       = 25'h1000000;
  localparam logic [PROD_W-1:0]  ROUND_Q24   = 49'h800000;
  localparam logic [K_W:0]       SHIFT_LIMIT = 8'd32;

  // 2^-(2^-(j+1)) in Q24, j = 0 is the weight of the top fraction bit
  function automatic logic [MUL_B_W-1:0] exp2_neg_q24(input logic [3:0] j);
    logic [MUL_B_W-1:0] c;
    case (j)
      4'd0:    c = 24'd11863283;
      4'd1:    c = 24'd14107901;
      4'd2:    c = 24'd15384775;
      4'd3:    c = 24'd16065917;
      4'd4:    c = 24'd16417715;
      4'd5:    c = 24'd16596491;
      4'd6:    c = 24'd16686609;
      4'd7:    c = 24'd16731851;
      4'd8:    c = 24'd16754518;
      4'd9:    c = 24'd16765863;
      4'd10:   c = 24'd16771539;
      4'd11:   c = 24'd16774377;
      4'd12:   c = 24'd16775797;
      4'd13:   c = 24'd16776506;
      4'd14:   c = 24'd16776861;
      default: c = 24'd16777039;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/gaussian_blur_tap_generator_unit.sv =====
// channel | dir | handshake               | payload
// setup   | in  | setup_valid/setup_stall | image_width, image_height, direction, deviation
// tap     | out | tap_valid/tap_stall     | tap_index, offset_x, offset_y, weight, last
//
// one setup beat yields 15 tap beats; a new setup is taken only once the last tap beat of
// the previous one is loaded and the sequencer is back in idle; the wait is shorter
// when far taps underflow to zero, longer for every cycle the tap side stalls
// the wait is set by the single shared divider (one quotient bit per cycle)
// plus 16 steps of the shared multiplier for each exponential
// rst is synchronous, active high; it clears the sequencer, tap_valid and the total
`include "assert_macros.svh"

module gaussian_blur_tap_generator_unit import gbt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    setup_valid,
  output logic                    setup_stall,
  input  logic [DIM_W-1:0]        image_width,
  input  logic [DIM_W-1:0]        image_height,
  input  logic                    direction,
  input  logic [DEV_W-1:0]        deviation,
  output logic                    tap_valid,
  input  logic                    tap_stall,
  output logic [3:0]              tap_index,
  output logic signed [OFS_W-1:0] offset_x,
  output logic signed [OFS_W-1:0] offset_y,
  output logic [WT_W-1:0]         weight,
  output logic                    last
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQR    = 4'd1;
  localparam logic [3:0] S_OFS_LD = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_OFS_WR = 4'd4;
  localparam logic [3:0] S_EXP_LD = 4'd5;
  localparam logic [3:0] S_EXP_Y  = 4'd6;
  localparam logic [3:0] S_POW    = 4'd7;
  localparam logic [3:0] S_RAW_WR = 4'd8;
  localparam logic [3:0] S_WT_LD  = 4'd9;
  localparam logic [3:0] S_WT_WR  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  // what the divider is working on, picks the state after the last step
  localparam logic [1:0] K_OFS = 2'd0;
  localparam logic [1:0] K_EXP = 2'd1;
  localparam logic [1:0] K_WT  = 2'd2;

  logic [3:0]       state;
  logic [1:0]       kind;
  logic [TAP_W-1:0] tap;
  logic [IDX_W-1:0] out_idx;
  logic [CNT_W-1:0] cnt;

  // latched setup beat
  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;
  logic             vert;
  logic [DEV_W-1:0] dev;

  // divider registers
  logic [DEN_W-1:0] d2;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] quo;

  // exponential registers
  logic [K_W-1:0]   k;
  logic [15:0]      f;
  logic [3:0]       j;
  logic [M_W-1:0]   m;
  logic             raw_zero;
  logic [TOT_W-1:0] total;

  // per-tap results, centre and positive side
  logic [RAW_W-1:0] raw_store [HALF_TAPS];
  logic [MAG_W-1:0] mags      [HALF_TAPS];
  logic [WT_W-1:0]  wts       [HALF_TAPS];

  logic [DIM_W-1:0]   size_sel;
  logic [DIM_W-1:0]   size_nz;
  logic [N_W-1:0]     n;
  logic [2*N_W-1:0]   n_sq;
  logic [NUM_W-1:0]   ofs_num;
  logic [DEN_W-1:0]   exp_rem0;
  logic [TOT_W-1:0]   t_nz;
  logic [NUM_W-1:0]   wt_num;
  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               fits;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  pow_sum;
  logic [M_W-1:0]     pow_m;
  logic [K_W:0]       sh;
  logic [RAW_W-1:0]   raw_val;
  logic [Q_OFS-1:0]   ofs_q;
  logic [MAG_W-1:0]   mag_val;
  logic [WT_W-1:0]    wt_val;
  logic [TAP_W-1:0]   src;
  logic               neg_side;
  logic [OFS_W-1:0]   mag_ext;
  logic [OFS_W-1:0]   beat_ofs;
  logic               beat_last;
  logic               load_beat;

  // only idle takes a new setup beat
  assign setup_stall = (state != S_IDLE);

  // pass axis size, zero treated as one pixel
  assign size_sel = vert ? img_h : img_w;
  assign size_nz  = (size_sel == '0) ? DIM_W'(1) : size_sel;

  // odd pixel distance of the current side tap
  assign n    = N_W'({tap, 1'b0}) - N_W'(1);
  assign n_sq = (2*N_W)'(n) * (2*N_W)'(n);

  // offset numerator n*2^16 + size/2, rounded division
  assign ofs_num = NUM_W'({n, 16'b0}) + NUM_W'(size_nz >> 1);

  // exponent numerator is n^2 * 2^31; its low quotient bits come from zeros,
  // so only the part above the quotient enters the remainder
  assign exp_rem0 = DEN_W'({n_sq, 9'b0});

  // weight numerator raw*2^16 + total/2
  assign t_nz   = (total == '0) ? TOT_W'(1) : total;
  assign wt_num = NUM_W'({raw_store[tap], 16'b0}) + NUM_W'(t_nz >> 1);

  // restoring divider step: one quotient bit per cycle
  assign trial = {rem, num[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});
  assign diff  = trial - {1'b0, den};

  // shared multiplier: sigma squared, x*log2(e), then the 2^-f product chain
  always_comb begin
    case (state)
      S_SQR: begin
        mul_a = MUL_A_W'(dev);
        mul_b = MUL_B_W'(dev);
      end
      S_EXP_Y: begin
        mul_a = MUL_A_W'(quo);
        mul_b = LOG2E_Q16;
      end
      default: begin
        mul_a = m;
        mul_b = exp2_neg_q24(j);
      end
    endcase
  end

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign pow_sum = prod + ROUND_Q24;
  assign pow_m   = pow_sum[PROD_W-1:24];

  // raw weight m >> (k+1), zero once the shift reaches the word size
  assign sh      = {1'b0, k} + (K_W+1)'(1);
  assign raw_val = (raw_zero || sh >= SHIFT_LIMIT) ? '0 : RAW_W'(m >> sh[4:0]);

  // offset magnitude saturates
  assign ofs_q   = quo[Q_OFS-1:0];
  assign mag_val = (ofs_q > {1'b0, OFS_MAX}) ? OFS_MAX : ofs_q[MAG_W-1:0];

  // normalized weight clamps at one
  assign wt_val = (quo[Q_WT-1:0] > WEIGHT_ONE) ? WEIGHT_ONE : quo[Q_WT-1:0];

  // beat order: centre, positive side, then mirrored negative side
  assign neg_side  = (out_idx >= IDX_W'(HALF_TAPS));
  assign src       = neg_side ? TAP_W'(out_idx - IDX_W'(HALF_TAPS - 1)) : TAP_W'(out_idx);
  assign mag_ext   = OFS_W'(mags[src]);
  assign beat_ofs  = neg_side ? (OFS_W'(0) - mag_ext) : mag_ext;
  assign beat_last = (out_idx == IDX_W'(TAP_CNT - 1));

  // load a beat whenever the output register is free or being taken
  assign load_beat = (state == S_OUT) && (!tap_valid || !tap_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= K_OFS;
      tap       <= '0;
      out_idx   <= '0;
      cnt       <= '0;
      tap_valid <= 1'b0;
      total     <= '0;
    end else begin
      // output register drains independently of the sequencer
      if (load_beat) begin
        tap_valid <= 1'b1;
      end else if (tap_valid && !tap_stall) begin
        tap_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (setup_valid) begin
            img_w <= image_width;
            img_h <= image_height;
            vert  <= direction;
            dev   <= deviation;
            state <= S_SQR;
          end
        end

        // sigma^2 once per setup; centre tap is fixed at 1.0
        S_SQR: begin
          d2           <= prod[DEN_W-1:0];
          raw_store[0] <= CENTRE_RAW;
          mags[0]      <= '0;
          total        <= TOT_W'(CENTRE_RAW);
          tap          <= TAP_W'(1);
          state        <= S_OFS_LD;
        end

        S_OFS_LD: begin
          rem   <= DEN_W'(ofs_num >> Q_OFS);
          num   <= ofs_num << (NUM_W - Q_OFS);
          den   <= DEN_W'(size_nz);
          cnt   <= CNT_W'(Q_OFS);
          quo   <= '0;
          kind  <= K_OFS;
          state <= S_DIV;
        end

        S_DIV: begin
          rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          quo <= {quo[QUO_W-2:0], fits};
          num <= num << 1;
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            case (kind)
              K_OFS:   state <= S_OFS_WR;
              K_EXP:   state <= S_EXP_Y;
              default: state <= S_WT_WR;
            endcase
          end
        end

        S_OFS_WR: begin
          mags[tap] <= mag_val;
          state     <= S_EXP_LD;
        end

        // zero deviation or an exponent of 2^22 and up gives a zero weight
        S_EXP_LD: begin
          if (dev == '0 || exp_rem0 >= d2) begin
            raw_zero <= 1'b1;
            state    <= S_RAW_WR;
          end else begin
            rem      <= exp_rem0;
            num      <= '0;
            den      <= d2;
            cnt      <= CNT_W'(Q_EXP);
            quo      <= '0;
            kind     <= K_EXP;
            raw_zero <= 1'b0;
            state    <= S_DIV;
          end
        end

        // exponent above 32.0 underflows, else split x*log2(e) into k and f
        S_EXP_Y: begin
          if (quo > X_LIMIT) begin
            raw_zero <= 1'b1;
            state    <= S_RAW_WR;
          end else begin
            k     <= prod[32 +: K_W];
            f     <= prod[31:16];
            m     <= M_ONE;
            j     <= '0;
            state <= S_POW;
          end
        end

        // one fraction bit per cycle, msb first
        S_POW: begin
          if (f[15]) begin
            m <= pow_m;
          end
          f <= f << 1;
          j <= j + 4'd1;
          if (j == 4'd15) begin
            state <= S_RAW_WR;
          end
        end

        // side weights count twice toward the total
        S_RAW_WR: begin
          raw_store[tap] <= raw_val;
          total          <= total + TOT_W'({raw_val, 1'b0});
          if (tap == TAP_W'(HALF_TAPS - 1)) begin
            tap   <= '0;
            state <= S_WT_LD;
          end else begin
            tap   <= tap + TAP_W'(1);
            state <= S_OFS_LD;
          end
        end

        S_WT_LD: begin
          rem   <= DEN_W'(wt_num >> Q_WT);
          num   <= wt_num << (NUM_W - Q_WT);
          den   <= DEN_W'(t_nz);
          cnt   <= CNT_W'(Q_WT);
          quo   <= '0;
          kind  <= K_WT;
          state <= S_DIV;
        end

        S_WT_WR: begin
          wts[tap] <= wt_val;
          if (tap == TAP_W'(HALF_TAPS - 1)) begin
            out_idx <= '0;
            state   <= S_OUT;
          end else begin
            tap   <= tap + TAP_W'(1);
            state <= S_WT_LD;
          end
        end

        // beat payload follows the valid set above
        S_OUT: begin
          if (load_beat) begin
            tap_index <= out_idx[3:0];
            offset_x  <= vert ? '0 : beat_ofs;
            offset_y  <= vert ? beat_ofs : '0;
            weight    <= wts[src];
            last      <= beat_last;
            if (beat_last) begin
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + IDX_W'(1);
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_div_count, clk, rst, state == S_DIV, cnt != '0, "divider ran past its last step")
  `ASSERT_IMPLY(a_total_centre, clk, rst, state == S_WT_LD, total >= TOT_W'(CENTRE_RAW), "weight total below centre weight")
  `ASSERT_IMPLY(a_weight_max, clk, rst, tap_valid, weight <= WEIGHT_ONE, "tap weight above one")
  `ASSERT_IMPLY(a_one_axis, clk, rst, tap_valid, offset_x == '0 || offset_y == '0, "offset on both axes")

endmodule
